// ----- rtl/core/brsf_pkg.sv -----
// Shared types and constants for the bitmap range scan and fill block.
package brsf_pkg;

   localparam int WORD_BITS = 32;
   localparam int OFF_W     = 5;                  // bit offset within a word
   localparam int BIT_W     = 12;                 // request bit index width
   localparam int IDX_W     = 13;                 // result bit index width
   localparam int WIDX_W    = BIT_W - OFF_W;      // word index width

   localparam logic [1:0] OP_FIND_ONE  = 2'd0;
   localparam logic [1:0] OP_FIND_ZERO = 2'd1;
   localparam logic [1:0] OP_SET       = 2'd2;
   localparam logic [1:0] OP_CLEAR     = 2'd3;

   localparam logic [WORD_BITS-1:0] ALL_ONES = 32'hffffffff;
   localparam logic [OFF_W-1:0]     TOP_BIT  = 5'd31;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [BIT_W-1:0] range_start;
      logic [BIT_W-1:0] range_end;
   } brsf_req_type;

   typedef struct packed {
      logic [IDX_W-1:0] bit_index;
      logic             found;
      logic             bad_range;
   } brsf_rsp_type;

   // Controls for one pass of the word unit
   typedef struct packed {
      logic [1:0]       op;
      logic             first;
      logic             last;
      logic [OFF_W-1:0] lo_off;
      logic [OFF_W-1:0] hi_off;
      logic             in_map;
   } brsf_word_ctl_type;

endpackage

// ----- rtl/core/bitmap_range_scan_and_fill.sv -----
// Top level: bitmap storage, clearing pass and word-walk sequencer.
//
// A request (operation, first bit, last bit) is taken at a clock edge where
// start is high and busy is low. Busy stays high while the request walks the
// bitmap one 32-bit word per cycle through a shared word unit, then the one
// result appears on rsp_data for a single cycle with rsp_valid high.
// Finds stop at the word holding the first match; set and clear do a
// read-modify-write of every word in the range, overlapped so that one word
// completes per cycle.
// Each word is read through the single registered memory read port, then
// evaluated by the word unit; the result is registered onto rsp_data.
// A reversed range raises rsp_valid in the cycle after acceptance with
// bad_range set and no change.
// A new request may be taken in the cycle the result is shown.
// After reset the block runs a clearing pass with busy high, zeroing every
// word before the first request is taken.
// Results cannot be held off by the receiver; each is shown once.
module bitmap_range_scan_and_fill #(
   parameter int MAP_WORDS = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  brsf_pkg::brsf_req_type req_data,
   output logic                   rsp_valid,
   output brsf_pkg::brsf_rsp_type rsp_data
);

   localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int WW = brsf_pkg::WIDX_W;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_SCAN  = 3'b100
   } state_type;

   state_type                      state_ff, state_in;
   logic [AW-1:0]                  clr_addr_ff, clr_addr_in;
   logic [1:0]                     op_ff, op_in;
   logic [brsf_pkg::BIT_W-1:0]     lo_ff, lo_in;
   logic [brsf_pkg::BIT_W-1:0]     hi_ff, hi_in;
   logic [WW:0]                    cur_word_ff, cur_word_in;
   logic                           pend_valid_ff, pend_valid_in;
   logic [WW-1:0]                  pend_word_ff, pend_word_in;
   logic                           pend_in_map_ff, pend_in_map_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   brsf_pkg::brsf_rsp_type         rsp_ff, rsp_in;

   logic [brsf_pkg::WORD_BITS-1:0] map_mem [MAP_WORDS];
   logic [brsf_pkg::WORD_BITS-1:0] rd_data_ff;
   logic                           mem_we, mem_re;
   logic [AW-1:0]                  mem_waddr, mem_raddr;
   logic [brsf_pkg::WORD_BITS-1:0] mem_wdata;

   brsf_pkg::brsf_word_ctl_type    wu_ctl;
   logic                           wu_hit;
   logic [brsf_pkg::OFF_W-1:0]     wu_pos;
   logic [brsf_pkg::WORD_BITS-1:0] wu_data;

   logic [AW+WW-1:0]               cur_ext, pend_ext;
   logic                           issue, cur_in_map, is_find, finish;

   assign cur_ext    = {{AW{1'b0}}, cur_word_ff[WW-1:0]};
   assign pend_ext   = {{AW{1'b0}}, pend_word_ff};
   assign cur_in_map = ({{(32-WW-1){1'b0}}, cur_word_ff} < 32'(MAP_WORDS));
   assign is_find    = (op_ff == brsf_pkg::OP_FIND_ONE) || (op_ff == brsf_pkg::OP_FIND_ZERO);

   assign wu_ctl.op     = op_ff;
   assign wu_ctl.first  = (pend_word_ff == lo_ff[brsf_pkg::BIT_W-1:brsf_pkg::OFF_W]);
   assign wu_ctl.last   = (pend_word_ff == hi_ff[brsf_pkg::BIT_W-1:brsf_pkg::OFF_W]);
   assign wu_ctl.lo_off = lo_ff[brsf_pkg::OFF_W-1:0];
   assign wu_ctl.hi_off = hi_ff[brsf_pkg::OFF_W-1:0];
   assign wu_ctl.in_map = pend_in_map_ff;

   brsf_word_unit u_word_unit (
      .ctl      (wu_ctl),
      .data_in  (rd_data_ff),
      .hit      (wu_hit),
      .hit_pos  (wu_pos),
      .data_out (wu_data)
   );

   // memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= map_mem[mem_raddr];
      end
   end

   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      op_in          = op_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      cur_word_in    = cur_word_ff;
      pend_valid_in  = 1'b0;
      pend_word_in   = pend_word_ff;
      pend_in_map_in = pend_in_map_ff;
      rsp_valid_in   = 1'b0;
      rsp_in         = rsp_ff;
      mem_we         = 1'b0;
      mem_waddr      = clr_addr_ff;
      mem_wdata      = '0;
      mem_re         = 1'b0;
      mem_raddr      = cur_ext[AW-1:0];
      issue          = 1'b0;
      finish         = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(MAP_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (req_data.range_end < req_data.range_start) begin
                  rsp_valid_in     = 1'b1;
                  rsp_in.bit_index = '0;
                  rsp_in.found     = 1'b0;
                  rsp_in.bad_range = 1'b1;
               end else begin
                  op_in       = req_data.req_type;
                  lo_in       = req_data.range_start;
                  hi_in       = req_data.range_end;
                  cur_word_in = {1'b0,
                     req_data.range_start[brsf_pkg::BIT_W-1:brsf_pkg::OFF_W]};
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // evaluate the word read last cycle
            if (pend_valid_ff) begin
               finish = (is_find && wu_hit) || wu_ctl.last;
               if (!is_find && pend_in_map_ff) begin
                  mem_we    = 1'b1;
                  mem_waddr = pend_ext[AW-1:0];
                  mem_wdata = wu_data;
               end
               if (finish) begin
                  state_in         = ST_IDLE;
                  rsp_valid_in     = 1'b1;
                  rsp_in.bad_range = 1'b0;
                  if (is_find && wu_hit) begin
                     rsp_in.bit_index = {1'b0, pend_word_ff, wu_pos};
                     rsp_in.found     = 1'b1;
                  end else if (is_find) begin
                     rsp_in.bit_index = {1'b0, hi_ff} + brsf_pkg::IDX_W'(1);
                     rsp_in.found     = 1'b0;
                  end else begin
                     rsp_in.bit_index = '0;
                     rsp_in.found     = 1'b0;
                  end
               end
            end
            // issue the next word read
            issue = (cur_word_ff <= {1'b0, hi_ff[brsf_pkg::BIT_W-1:brsf_pkg::OFF_W]});
            if (issue) begin
               mem_re         = cur_in_map;
               cur_word_in    = cur_word_ff + (WW + 1)'(1);
               pend_valid_in  = !finish;
               pend_word_in   = cur_word_ff[WW-1:0];
               pend_in_map_in = cur_in_map;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      cur_word_ff    <= cur_word_in;
      pend_word_ff   <= pend_word_in;
      pend_in_map_ff <= pend_in_map_in;
      rsp_ff         <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- rtl/core/brsf_word_unit.sv -----
// Per-word range mask, lowest-match search and fill merge.
module brsf_word_unit (
   input  brsf_pkg::brsf_word_ctl_type          ctl,
   input  logic [brsf_pkg::WORD_BITS-1:0]       data_in,
   output logic                                 hit,
   output logic [brsf_pkg::OFF_W-1:0]           hit_pos,
   output logic [brsf_pkg::WORD_BITS-1:0]       data_out
);

   logic [brsf_pkg::WORD_BITS-1:0] word;
   logic [brsf_pkg::WORD_BITS-1:0] lo_mask;
   logic [brsf_pkg::WORD_BITS-1:0] hi_mask;
   logic [brsf_pkg::WORD_BITS-1:0] mask;
   logic [brsf_pkg::WORD_BITS-1:0] cand;
   logic [brsf_pkg::WORD_BITS-1:0] lowest;

   // words past the end of the map read as zero
   assign word    = ctl.in_map ? data_in : '0;
   assign lo_mask = ctl.first ? (brsf_pkg::ALL_ONES << ctl.lo_off) : brsf_pkg::ALL_ONES;
   assign hi_mask = ctl.last ?
                    (brsf_pkg::ALL_ONES >> (brsf_pkg::TOP_BIT - ctl.hi_off)) :
                    brsf_pkg::ALL_ONES;
   assign mask    = lo_mask & hi_mask;
   assign cand    = ((ctl.op == brsf_pkg::OP_FIND_ONE) ? word : ~word) & mask;
   assign lowest  = cand & (~cand + 32'd1);
   assign hit     = |cand;

   always_comb begin
      hit_pos = '0;
      for (int b = 0; b < brsf_pkg::OFF_W; b++) begin
         for (int i = 0; i < brsf_pkg::WORD_BITS; i++) begin
            if (((i >> b) & 1) == 1) begin
               hit_pos[b] = hit_pos[b] | lowest[i];
            end
         end
      end
   end

   assign data_out = (ctl.op == brsf_pkg::OP_SET) ? (word | mask) : (word & ~mask);

endmodule
